FILE: sv/bcs_pkg.sv
// Shared types, codes and reset values for the battery cycle sequencer.
// Used by battery_cycle_sequencer and bcs_checker; no dependencies of its own.
package bcs_pkg;

    // Field widths fixed by the interface
    localparam int CFG_W       = 26;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_CFG     = 6;
    localparam int MODE_W      = 3;
    localparam int CYC_PORT_W  = 8;
    localparam int LEVEL_W     = 2;

    // Parameter defaults
    localparam int TIMER_BITS_DEF = 26;
    localparam int CYCLE_BITS_DEF = 8;

    // Failed reads in a row that abort a process
    localparam logic [1:0] ERR_LIMIT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_CHARGE_WAIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_WAIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_WAIT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEMO_WAIT         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEMO_PHASE_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_INTERVAL     = 3'd5;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
        26'd1800000, 26'd18000000, 26'd3600000, 26'd5000, 26'd10000, 26'd1000
    };

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CHARGE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DISCHARGE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CALIB     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEMO      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STOP      = 3'd5;

    // Relay pair: bit 0 charge, bit 1 discharge
    localparam logic [1:0] RELAY_NONE = 2'b00;
    localparam logic [1:0] RELAY_CHG  = 2'b01;
    localparam logic [1:0] RELAY_DIS  = 2'b10;

    // Demo data levels
    localparam logic [LEVEL_W-1:0] LVL_DISCHARGING = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_CHARGING    = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_RESTING     = 2'd2;

    typedef enum logic [2:0] {
        PROC_IDLE      = 3'd0,
        PROC_CHARGE    = 3'd1,
        PROC_DISCHARGE = 3'd2,
        PROC_CALIB     = 3'd3,
        PROC_DEMO      = 3'd4
    } process_t;

    typedef enum logic [2:0] {
        PH_PRE_CHARGE   = 3'd0,
        PH_PRE_WAIT     = 3'd1,
        PH_START_DIS    = 3'd2,
        PH_DISCHARGING  = 3'd3,
        PH_DIS_WAIT     = 3'd4,
        PH_START_CHG    = 3'd5,
        PH_CHARGING     = 3'd6,
        PH_CHG_WAIT     = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        LED_OFF  = 3'd0,
        LED_CHG  = 3'd1,
        LED_DIS  = 3'd2,
        LED_DONE = 3'd3,
        LED_WAIT = 3'd4
    } led_t;

    typedef enum logic [2:0] {
        FIN_NONE     = 3'd0,
        FIN_COMPLETE = 3'd1,
        FIN_FAULT    = 3'd2,
        FIN_FET      = 3'd3,
        FIN_READ_ERR = 3'd4,
        FIN_STOP     = 3'd5
    } finish_t;

endpackage

FILE: sv/battery_cycle_sequencer.sv
// Battery charge/discharge/calibration sequencer, one state update per beat; uses bcs_pkg.
// Latency: a result beat is valid the cycle after its input beat is accepted.
// Throughput: one beat per cycle; s_ready drops only while a result is held.
// The whole update is one combinational pass from state and input into the
// state and result registers. Reset (aresetn, synchronous, active low): idle,
// relays and LED off, configuration back to its defaults, no result pending.
module battery_cycle_sequencer
    import bcs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int CYCLE_BITS = CYCLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    // input beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MODE_W-1:0]     s_mode,
    input  logic [CYC_PORT_W-1:0] s_cycles,
    input  logic                  s_read_ok,
    input  logic                  s_full_charge,
    input  logic                  s_full_discharge,
    input  logic                  s_charge_blocked,
    input  logic                  s_discharge_blocked,
    input  logic                  s_battery_fault,
    // result beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_charge_relay,
    output logic                  m_discharge_relay,
    output logic [2:0]            m_led_pattern,
    output logic                  m_busy_res,
    output logic [2:0]            m_process_now,
    output logic [2:0]            m_phase_now,
    output logic [CYC_PORT_W-1:0] m_cycle_now,
    output logic                  m_read_due,
    output logic [LEVEL_W-1:0]    m_demo_level,
    output logic [2:0]            m_finish_reason
);

    // Compare width wide enough for both timers and config values
    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    // Configuration registers
    logic [CFG_W-1:0] cfg_reg [NUM_CFG];

    // Sequencer state
    process_t              process_reg, process_next;
    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] step_reg, step_next;
    logic [TIMER_BITS-1:0] read_reg, read_next;
    logic                  pend_reg, pend_next;
    logic [1:0]            err_reg, err_next;
    logic [CYCLE_BITS-1:0] cnt_reg, cnt_next;
    logic [CYCLE_BITS-1:0] tgt_reg, tgt_next;
    logic [1:0]            relay_reg, relay_next;
    led_t                  led_reg, led_next;

    // Per-beat side results
    logic                  rdue;
    logic [LEVEL_W-1:0]    lvl;
    finish_t               reason;

    // Result register
    logic                  m_valid_reg;
    logic [1:0]            res_relay_reg;
    led_t                  res_led_reg;
    process_t              res_proc_reg;
    phase_t                res_phase_reg;
    logic [CYC_PORT_W-1:0] res_cyc_reg;
    logic                  res_rdue_reg;
    logic [LEVEL_W-1:0]    res_lvl_reg;
    finish_t               res_reason_reg;

    // Helper terms for a tick
    logic                  accept;
    logic                  is_demo;
    logic [TIMER_BITS-1:0] step_bump;
    logic [TIMER_BITS-1:0] read_bump;
    logic                  read_hit;
    logic                  phase_len_hit;
    logic [CFG_W-1:0]      wait_lim;
    logic                  wait_done;
    logic [1:0]            err_inc;
    logic                  stop_charge;
    logic                  stop_dis;
    finish_t               chg_reason;
    finish_t               dis_reason;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end else if (cfg_valid && cfg_ready && (32'(cfg_index) < NUM_CFG)) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Saturating timers, read pacing, wait and phase-length compares
    always_comb begin
        is_demo   = (process_reg == PROC_DEMO);
        step_bump = (step_reg == '1) ? step_reg : step_reg + 1'b1;
        read_bump = (read_reg == '1) ? read_reg : read_reg + 1'b1;
        read_hit  = pend_reg ||
                    (CMP_W'(read_bump) >= CMP_W'(cfg_reg[CFG_READ_INTERVAL]));
        phase_len_hit = is_demo &&
                    (CMP_W'(step_bump) > CMP_W'(cfg_reg[CFG_DEMO_PHASE_LENGTH]));
        if (is_demo) begin
            wait_lim = cfg_reg[CFG_DEMO_WAIT];
        end else if (phase_reg == PH_PRE_WAIT) begin
            wait_lim = cfg_reg[CFG_PRE_CHARGE_WAIT];
        end else if (phase_reg == PH_DIS_WAIT) begin
            wait_lim = cfg_reg[CFG_DISCHARGE_WAIT];
        end else begin
            wait_lim = cfg_reg[CFG_CHARGE_WAIT];
        end
        wait_done = CMP_W'(step_bump) > CMP_W'(wait_lim);
        err_inc   = (err_reg < ERR_LIMIT) ? err_reg + 2'd1 : err_reg;
        // simple charge / discharge end conditions, fault first
        stop_charge = s_full_charge || s_charge_blocked || s_battery_fault;
        stop_dis    = s_full_discharge || s_discharge_blocked || s_battery_fault;
        chg_reason  = s_battery_fault ? FIN_FAULT :
                      (s_charge_blocked ? FIN_FET : FIN_COMPLETE);
        dis_reason  = s_battery_fault ? FIN_FAULT :
                      (s_discharge_blocked ? FIN_FET : FIN_COMPLETE);
    end

    // Next state for one input beat
    always_comb begin
        process_next = process_reg;
        phase_next   = phase_reg;
        step_next    = step_reg;
        read_next    = read_reg;
        pend_next    = pend_reg;
        err_next     = err_reg;
        cnt_next     = cnt_reg;
        tgt_next     = tgt_reg;
        relay_next   = relay_reg;
        led_next     = led_reg;
        rdue         = 1'b0;
        lvl          = LVL_DISCHARGING;
        reason       = FIN_NONE;

        unique case (s_mode)
            MODE_CHARGE, MODE_DISCHARGE, MODE_CALIB, MODE_DEMO: begin
                err_next  = '0;
                step_next = '0;
                read_next = '0;
                pend_next = 1'b1;
                if (s_mode == MODE_CHARGE) begin
                    process_next = PROC_CHARGE;
                    relay_next   = RELAY_CHG;
                    led_next     = LED_CHG;
                end else if (s_mode == MODE_DISCHARGE) begin
                    process_next = PROC_DISCHARGE;
                    relay_next   = RELAY_DIS;
                    led_next     = LED_DIS;
                end else begin
                    // relays and LED hold until the first tick
                    process_next = (s_mode == MODE_CALIB) ? PROC_CALIB : PROC_DEMO;
                    tgt_next     = CYCLE_BITS'(s_cycles);
                    cnt_next     = CYCLE_BITS'(1);
                    phase_next   = PH_PRE_CHARGE;
                end
            end
            MODE_STOP: begin
                reason       = (process_reg != PROC_IDLE) ? FIN_STOP : FIN_NONE;
                process_next = PROC_IDLE;
                relay_next   = RELAY_NONE;
                led_next     = LED_OFF;
                err_next     = '0;
            end
            MODE_TICK: begin
                if (process_reg != PROC_IDLE) begin
                    step_next = step_bump;
                    read_next = read_bump;
                    // battery read or demo data generation
                    if (read_hit) begin
                        pend_next = 1'b0;
                        read_next = '0;
                        rdue      = 1'b1;
                        if (is_demo) begin
                            if (phase_reg == PH_CHARGING || phase_reg == PH_PRE_CHARGE) begin
                                lvl = LVL_CHARGING;
                            end else if (phase_reg != PH_DISCHARGING) begin
                                lvl = LVL_RESTING;
                            end
                        end else if (!s_read_ok) begin
                            err_next = err_inc;
                        end else begin
                            err_next = '0;
                        end
                    end

                    if (read_hit && !is_demo && !s_read_ok && err_inc >= ERR_LIMIT) begin
                        // abort: the rest of the tick is skipped
                        process_next = PROC_IDLE;
                        relay_next   = RELAY_NONE;
                        led_next     = LED_OFF;
                        err_next     = '0;
                        reason       = FIN_READ_ERR;
                    end else if (process_reg == PROC_CHARGE) begin
                        if (stop_charge) begin
                            reason       = chg_reason;
                            process_next = PROC_IDLE;
                            relay_next   = RELAY_NONE;
                            led_next     = LED_OFF;
                            err_next     = '0;
                        end
                    end else if (process_reg == PROC_DISCHARGE) begin
                        if (stop_dis) begin
                            reason       = dis_reason;
                            process_next = PROC_IDLE;
                            relay_next   = RELAY_NONE;
                            led_next     = LED_OFF;
                            err_next     = '0;
                        end
                    end else begin
                        // calibration / demo step sequence
                        unique case (phase_reg)
                            PH_PRE_CHARGE, PH_CHARGING: begin
                                if (phase_reg == PH_PRE_CHARGE) begin
                                    relay_next = RELAY_CHG;
                                    led_next   = LED_CHG;
                                end
                                if (phase_len_hit || stop_charge) begin
                                    led_next   = LED_DONE;
                                    step_next  = '0;
                                    phase_next = (phase_reg == PH_PRE_CHARGE) ?
                                                 PH_PRE_WAIT : PH_CHG_WAIT;
                                end
                            end
                            PH_PRE_WAIT: begin
                                if (wait_done) phase_next = PH_START_DIS;
                            end
                            PH_START_DIS: begin
                                relay_next = RELAY_DIS;
                                led_next   = LED_DIS;
                                step_next  = '0;
                                phase_next = PH_DISCHARGING;
                            end
                            PH_DISCHARGING: begin
                                if (phase_len_hit || stop_dis) begin
                                    relay_next = RELAY_NONE;
                                    led_next   = LED_WAIT;
                                    step_next  = '0;
                                    phase_next = PH_DIS_WAIT;
                                end
                            end
                            PH_DIS_WAIT: begin
                                if (wait_done) phase_next = PH_START_CHG;
                            end
                            PH_START_CHG: begin
                                relay_next = RELAY_CHG;
                                led_next   = LED_CHG;
                                step_next  = '0;
                                phase_next = PH_CHARGING;
                            end
                            PH_CHG_WAIT: begin
                                if (wait_done) begin
                                    if (cnt_reg < tgt_reg) begin
                                        cnt_next   = cnt_reg + 1'b1;
                                        phase_next = PH_START_DIS;
                                    end else begin
                                        process_next = PROC_IDLE;
                                        relay_next   = RELAY_NONE;
                                        led_next     = LED_OFF;
                                        err_next     = '0;
                                        reason       = FIN_COMPLETE;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            default: begin
                // unknown mode: status only
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            process_reg <= PROC_IDLE;
            phase_reg   <= PH_PRE_CHARGE;
            step_reg    <= '0;
            read_reg    <= '0;
            pend_reg    <= 1'b0;
            err_reg     <= '0;
            cnt_reg     <= '0;
            tgt_reg     <= '0;
            relay_reg   <= RELAY_NONE;
            led_reg     <= LED_OFF;
        end else if (accept) begin
            process_reg <= process_next;
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            read_reg    <= read_next;
            pend_reg    <= pend_next;
            err_reg     <= err_next;
            cnt_reg     <= cnt_next;
            tgt_reg     <= tgt_next;
            relay_reg   <= relay_next;
            led_reg     <= led_next;
        end
    end

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_relay_reg  <= relay_next;
            res_led_reg    <= led_next;
            res_proc_reg   <= process_next;
            res_phase_reg  <= phase_next;
            res_cyc_reg    <= CYC_PORT_W'(cnt_next);
            res_rdue_reg   <= rdue;
            res_lvl_reg    <= lvl;
            res_reason_reg <= reason;
        end
    end

    // Output ports
    always_comb begin
        m_valid           = m_valid_reg;
        m_charge_relay    = res_relay_reg[0];
        m_discharge_relay = res_relay_reg[1];
        m_led_pattern     = res_led_reg;
        m_busy_res        = (res_proc_reg != PROC_IDLE);
        m_process_now     = res_proc_reg;
        m_phase_now       = res_phase_reg;
        m_cycle_now       = res_cyc_reg;
        m_read_due        = res_rdue_reg;
        m_demo_level      = res_lvl_reg;
        m_finish_reason   = res_reason_reg;
    end

endmodule

FILE: sv/bcs_checker.sv
// Port-level assertions for battery_cycle_sequencer, attached by bind.
// Depends on bcs_pkg and the top level's port list.
module bcs_checker
    import bcs_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_charge_relay,
    input logic                  m_discharge_relay,
    input logic [2:0]            m_led_pattern,
    input logic                  m_busy_res,
    input logic [2:0]            m_process_now,
    input logic [CYC_PORT_W-1:0] m_cycle_now,
    input logic [2:0]            m_finish_reason
);

    // Input side stalls only while a result beat is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow result back-pressure");

    // A held result beat keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_finish_reason)
            && $stable(m_process_now) && $stable(m_charge_relay)
            && $stable(m_discharge_relay) && $stable(m_cycle_now))
        else $error("stalled result beat changed");

    // Never both relays on
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_charge_relay && m_discharge_relay))
        else $error("charge and discharge relays both on");

    // Idle means relays and LED off
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> !m_charge_relay && !m_discharge_relay
            && m_led_pattern == LED_OFF)
        else $error("relay or LED active while idle");

    // A finish reason only comes with the process ending
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finish_reason != FIN_NONE |-> !m_busy_res
            && m_process_now == PROC_IDLE)
        else $error("finish reason reported while still busy");

endmodule

bind battery_cycle_sequencer bcs_checker u_bcs_checker (.*);
